// ----- hdl/mtu_pkg.sv -----
// Shared types and constants for the multiturn angle unwrap block.
package mtu_pkg;

	localparam int unsigned RESOLUTION = 16384;

	localparam int RAW_W  = 15;
	localparam int WORD_W = 16;
	localparam int POS_W  = 48;
	localparam int TURN_W = 32;
	localparam int CMP_W  = 18;

	localparam logic [CMP_W-1:0] RES_CMP   = CMP_W'(RESOLUTION);
	localparam logic [CMP_W-1:0] RES3_CMP  = CMP_W'(3 * RESOLUTION);
	localparam logic signed [POS_W-1:0] RES_POS   = POS_W'(RESOLUTION);
	localparam logic signed [POS_W-1:0] HALF_TURN = POS_W'(RESOLUTION / 2);

	localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
	localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

	typedef enum logic [1:0] {
		SIGN_ZERO = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic {
		CMD_SAMPLE  = 1'b0,
		CMD_SETZERO = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_SETZERO = 2'd1,
		KIND_BLANK   = 2'd2
	} kind_t;

	// Request held in the input register.
	typedef struct packed {
		logic             vld;
		cmd_t             cmd;
		logic [RAW_W-1:0] raw;
	} sample_t;

	// Request leaving the turn tracker.
	typedef struct packed {
		logic                    vld;
		kind_t                   kind;
		logic signed [POS_W-1:0] pos;
	} track_t;

endpackage

// ----- hdl/mtu_track.sv -----
// Turn tracker: sign and quarter detection, saturating turn count, absolute position.
module mtu_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             enable,
	input  mtu_pkg::sample_t smp,
	output mtu_pkg::track_t  trk
);
	import mtu_pkg::*;

	sign_t                    prev_sign_q;
	logic signed [TURN_W-1:0] turn_q;
	logic signed [POS_W-1:0]  basec_q;
	logic signed [POS_W-1:0]  basec_inc_q;
	logic signed [POS_W-1:0]  basec_dec_q;
	logic signed [POS_W-1:0]  last_pos_q;
	logic                     vld_s2;
	kind_t                    kind_s2;
	logic signed [POS_W-1:0]  pos_s2;

	logic [CMP_W-1:0]        two_m;
	logic [CMP_W-1:0]        four_m;
	sign_t                   sign_nx;
	logic                    outer;
	logic                    do_inc;
	logic                    do_dec;
	logic signed [POS_W-1:0] basec_nx;
	logic signed [POS_W-1:0] pos_nx;
	logic                    live;
	logic                    sample_go;

	always_comb begin
		two_m  = {2'b00, smp.raw, 1'b0};
		four_m = {1'b0, smp.raw, 2'b00};
		if (two_m > RES_CMP) begin
			sign_nx = SIGN_POS;
		end else if (two_m < RES_CMP) begin
			sign_nx = SIGN_NEG;
		end else begin
			sign_nx = SIGN_ZERO;
		end
		outer  = (four_m > RES3_CMP) || (four_m < RES_CMP);
		do_dec = outer && (sign_nx == SIGN_POS) && (prev_sign_q == SIGN_NEG)
			&& (turn_q != TURN_MIN);
		do_inc = outer && (sign_nx == SIGN_NEG) && (prev_sign_q == SIGN_POS)
			&& (turn_q != TURN_MAX);
		if (do_dec) begin
			basec_nx = basec_dec_q;
		end else if (do_inc) begin
			basec_nx = basec_inc_q;
		end else begin
			basec_nx = basec_q;
		end
		// base already carries the half-turn offset, so only the raw count is added
		pos_nx    = basec_nx + $signed({{(POS_W-RAW_W){1'b0}}, smp.raw});
		live      = advance && smp.vld;
		sample_go = live && (smp.cmd == CMD_SAMPLE) && enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sign_q <= SIGN_ZERO;
			turn_q      <= '0;
			basec_q     <= -HALF_TURN;
			basec_inc_q <= RES_POS - HALF_TURN;
			basec_dec_q <= -RES_POS - HALF_TURN;
			last_pos_q  <= '0;
			vld_s2      <= 1'b0;
		end else begin
			if (advance) begin
				vld_s2 <= smp.vld;
			end
			if (sample_go) begin
				prev_sign_q <= sign_nx;
				last_pos_q  <= pos_nx;
				if (do_dec) begin
					turn_q      <= turn_q - TURN_W'(1);
					basec_q     <= basec_dec_q;
					basec_inc_q <= basec_q;
					basec_dec_q <= basec_dec_q - RES_POS;
				end else if (do_inc) begin
					turn_q      <= turn_q + TURN_W'(1);
					basec_q     <= basec_inc_q;
					basec_dec_q <= basec_q;
					basec_inc_q <= basec_inc_q + RES_POS;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (live) begin
			if (smp.cmd == CMD_SETZERO) begin
				kind_s2 <= KIND_SETZERO;
				pos_s2  <= last_pos_q;
			end else if (enable) begin
				kind_s2 <= KIND_SAMPLE;
				pos_s2  <= pos_nx;
			end else begin
				kind_s2 <= KIND_BLANK;
				pos_s2  <= '0;
			end
		end
	end

	assign trk.vld  = vld_s2;
	assign trk.kind = kind_s2;
	assign trk.pos  = pos_s2;

	a_inc_span: assert property (@(posedge clk) disable iff (!arst_n)
		basec_inc_q - basec_q == RES_POS)
		else $error("increment base out of step with base");

	a_dec_span: assert property (@(posedge clk) disable iff (!arst_n)
		basec_q - basec_dec_q == RES_POS)
		else $error("decrement base out of step with base");

	a_turn_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_go && !outer) |=> (turn_q == $past(turn_q)))
		else $error("turn count moved outside the outer quarters");

endmodule

// ----- hdl/mtu_offset.sv -----
// Zero offset store and result register with relative position.
module mtu_offset (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  mtu_pkg::track_t                 trk,
	output logic                            out_vld,
	output logic signed [mtu_pkg::POS_W-1:0] abs_pos,
	output logic signed [mtu_pkg::POS_W-1:0] rel_pos
);
	import mtu_pkg::*;

	logic                    vld_q;
	logic signed [POS_W-1:0] zero_q;
	logic signed [POS_W-1:0] abs_q;
	logic signed [POS_W-1:0] rel_q;
	logic                    take;

	assign take = advance && trk.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			zero_q <= '0;
		end else begin
			if (advance) begin
				vld_q <= trk.vld;
			end
			if (take && (trk.kind == KIND_SETZERO)) begin
				zero_q <= trk.pos;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (trk.kind)
				KIND_SAMPLE: begin
					abs_q <= trk.pos;
					rel_q <= trk.pos - zero_q;
				end
				KIND_SETZERO: begin
					abs_q <= trk.pos;
					rel_q <= '0;
				end
				default: begin
					abs_q <= '0;
					rel_q <= '0;
				end
			endcase
		end
	end

	assign out_vld = vld_q;
	assign abs_pos = abs_q;
	assign rel_pos = rel_q;

	a_setzero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(take && trk.kind == KIND_SETZERO) |=> (vld_q && rel_q == '0 && zero_q == abs_q))
		else $error("set-zero result does not match the captured offset");

endmodule

// ----- hdl/multiturn_angle_unwrap.sv -----
// Top level of the multiturn angle unwrap block: input register, tracker, offset stage.
// An accepted request passes the input register, the tracker register and the result
// register before its result shows on m_axis.
// Throughput: one request per clock while m_axis is not stalled.
// The whole pipeline stalls together while a result waits on m_axis_tready.
// Reset (arst_n low, asynchronous): turn count, sign, last position and zero offset clear,
// enable clears, and all valid flags drop.
module multiturn_angle_unwrap (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic                                cfg_wdata,  // enable
	// input stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [mtu_pkg::WORD_W-1:0]          s_axis_tdata,   // [14:0] raw_sample, bit 15 ignored
	input  logic                                s_axis_tuser,   // [0] command
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [2*mtu_pkg::POS_W-1:0]         m_axis_tdata    // [47:0] absolute_position,
	                                                            // [95:48] relative_position
);
	import mtu_pkg::*;

	logic                    enable_q;
	logic                    smp_vld_s1;
	cmd_t                    smp_cmd_s1;
	logic [RAW_W-1:0]        smp_raw_s1;
	sample_t                 smp_s1;
	track_t                  trk;
	logic                    advance;
	logic signed [POS_W-1:0] abs_pos;
	logic signed [POS_W-1:0] rel_pos;

	// Advance every stage whenever the result register is empty or being drained.
	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			smp_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (advance) begin
				smp_vld_s1 <= s_axis_tvalid;
			end
		end
	end

	// Capture the payload on accept; bit 15 of the raw word is dropped here.
	always_ff @(posedge clk) begin
		if (advance && s_axis_tvalid) begin
			smp_cmd_s1 <= cmd_t'(s_axis_tuser);
			smp_raw_s1 <= s_axis_tdata[RAW_W-1:0];
		end
	end

	assign smp_s1 = {smp_vld_s1, smp_cmd_s1, smp_raw_s1};

	mtu_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.enable  (enable_q),
		.smp     (smp_s1),
		.trk     (trk)
	);

	mtu_offset u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.trk     (trk),
		.out_vld (m_axis_tvalid),
		.abs_pos (abs_pos),
		.rel_pos (rel_pos)
	);

	assign m_axis_tdata = {rel_pos, abs_pos};

endmodule
